// File: sv/mwo_pkg.sv
package mwo_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BASE_FREQ  = 3'd0;
  localparam logic [2:0] REG_FM_AMOUNT  = 3'd1;
  localparam logic [2:0] REG_PULSE_W    = 3'd2;
  localparam logic [2:0] REG_WM_AMOUNT  = 3'd3;
  localparam logic [2:0] REG_STEP_PERHZ = 3'd4;

  localparam logic [35:0] STEP_RESET = 36'd5864062015;

  // series constants for table generation
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // clamps
  localparam logic [21:0] FREQ_MIN  = 22'd2093;
  localparam logic [21:0] FREQ_MAX  = 22'd3211227;
  localparam logic [15:0] WIDTH_MIN = 16'd655;
  localparam logic [15:0] WIDTH_MAX = 16'd64881;

  typedef struct packed {
    logic [21:0] base_frequency;
    logic [15:0] freq_mod_amount;
    logic [15:0] pulse_width;
    logic [15:0] width_mod_amount;
    logic [35:0] phase_step_per_hz;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_SPLIT, OP_IDX1, OP_IDX2, OP_EXPRD, OP_BASE, OP_SHIFT,
    OP_FMHI, OP_FMLO, OP_FMSUM, OP_FCLAMP, OP_INCLO, OP_INCHI, OP_INCSUM,
    OP_PHASE, OP_SINEIDX, OP_SINERD, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// File: sv/multi_waveform_phase_oscillator_core.sv
// channel | beat contents                                   | handshake
// input   | freq_mod, width_mod, pitch_semitones, sync_in    | in_valid / in_stall
// output  | sine_out, triangle_out, saw_out, square_out,     | out_valid / out_stall
//         | pulse_out                                        |
// config  | cfg_index, cfg_data                              | cfg_write
//
// one beat steps through the sequencer states from acceptance to its result being
// registered, a sequence set by the single shared 33x18 multiplier taking nine
// products in turn; a new beat is taken only in idle, after the last one finishes
// a finished result sits in the output register while the next beat is taken in
// a result held by out_stall only delays the next load at the last step
// synchronous reset clears phase, sync history and handshake state, resets config
module multi_waveform_phase_oscillator_core #(
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int EXP_TABLE_DEPTH  = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [35:0]                   cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            freq_mod,
  input  logic signed [15:0]            width_mod,
  input  logic signed [15:0]            pitch_semitones,
  input  logic signed [15:0]            sync_in,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sine_out,
  output logic signed [SAMPLE_BITS-1:0] triangle_out,
  output logic signed [SAMPLE_BITS-1:0] saw_out,
  output logic signed [SAMPLE_BITS-1:0] square_out,
  output logic signed [SAMPLE_BITS-1:0] pulse_out
);
  import mwo_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // register file, only the low bits of each write are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_frequency    <= '0;
      cfg.freq_mod_amount   <= '0;
      cfg.pulse_width       <= '0;
      cfg.width_mod_amount  <= '0;
      cfg.phase_step_per_hz <= STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_FREQ:  cfg.base_frequency    <= cfg_data[21:0];
        REG_FM_AMOUNT:  cfg.freq_mod_amount   <= cfg_data[15:0];
        REG_PULSE_W:    cfg.pulse_width       <= cfg_data[15:0];
        REG_WM_AMOUNT:  cfg.width_mod_amount  <= cfg_data[15:0];
        REG_STEP_PERHZ: cfg.phase_step_per_hz <= cfg_data;
        default: begin
          // writes past the last register are dropped
        end
      endcase
    end
  end

  // sequencer: one step per cycle, waits at the end for a free output register
  mwo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: tables, shared multiplier, phase accumulator, waveform shaping
  mwo_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg             (cfg),
    .freq_mod        (freq_mod),
    .width_mod       (width_mod),
    .pitch_semitones (pitch_semitones),
    .sync_in         (sync_in),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .sine_out        (sine_out),
    .triangle_out    (triangle_out),
    .saw_out         (saw_out),
    .square_out      (square_out),
    .pulse_out       (pulse_out)
  );

endmodule

// File: sv/mwo_ctrl.sv
module mwo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mwo_pkg::stat_t stat,
  output mwo_pkg::cmd_t  cmd
);
  import mwo_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_SPLIT   = 18'h00002,
    ST_IDX1    = 18'h00004,
    ST_IDX2    = 18'h00008,
    ST_EXPRD   = 18'h00010,
    ST_BASE    = 18'h00020,
    ST_SHIFT   = 18'h00040,
    ST_FMHI    = 18'h00080,
    ST_FMLO    = 18'h00100,
    ST_FMSUM   = 18'h00200,
    ST_FCLAMP  = 18'h00400,
    ST_INCLO   = 18'h00800,
    ST_INCHI   = 18'h01000,
    ST_INCSUM  = 18'h02000,
    ST_PHASE   = 18'h04000,
    ST_SINEIDX = 18'h08000,
    ST_SINERD  = 18'h10000,
    ST_FINISH  = 18'h20000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT:   begin cmd.op = OP_SPLIT;   state_next = ST_IDX1;    end
      ST_IDX1:    begin cmd.op = OP_IDX1;    state_next = ST_IDX2;    end
      ST_IDX2:    begin cmd.op = OP_IDX2;    state_next = ST_EXPRD;   end
      ST_EXPRD:   begin cmd.op = OP_EXPRD;   state_next = ST_BASE;    end
      ST_BASE:    begin cmd.op = OP_BASE;    state_next = ST_SHIFT;   end
      ST_SHIFT:   begin cmd.op = OP_SHIFT;   state_next = ST_FMHI;    end
      ST_FMHI:    begin cmd.op = OP_FMHI;    state_next = ST_FMLO;    end
      ST_FMLO:    begin cmd.op = OP_FMLO;    state_next = ST_FMSUM;   end
      ST_FMSUM:   begin cmd.op = OP_FMSUM;   state_next = ST_FCLAMP;  end
      ST_FCLAMP:  begin cmd.op = OP_FCLAMP;  state_next = ST_INCLO;   end
      ST_INCLO:   begin cmd.op = OP_INCLO;   state_next = ST_INCHI;   end
      ST_INCHI:   begin cmd.op = OP_INCHI;   state_next = ST_INCSUM;  end
      ST_INCSUM:  begin cmd.op = OP_INCSUM;  state_next = ST_PHASE;   end
      ST_PHASE:   begin cmd.op = OP_PHASE;   state_next = ST_SINEIDX; end
      ST_SINEIDX: begin cmd.op = OP_SINEIDX; state_next = ST_SINERD;  end
      ST_SINERD:  begin cmd.op = OP_SINERD;  state_next = ST_FINISH;  end
      ST_FINISH: begin
        cmd.op = OP_FINISH;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/mwo_datapath.sv
module mwo_datapath #(
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int EXP_TABLE_DEPTH  = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mwo_pkg::cmd_t                 cmd,
  output mwo_pkg::stat_t                stat,
  input  mwo_pkg::cfg_t                 cfg,
  input  logic signed [15:0]            freq_mod,
  input  logic signed [15:0]            width_mod,
  input  logic signed [15:0]            pitch_semitones,
  input  logic signed [15:0]            sync_in,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] sine_out,
  output logic signed [SAMPLE_BITS-1:0] triangle_out,
  output logic signed [SAMPLE_BITS-1:0] saw_out,
  output logic signed [SAMPLE_BITS-1:0] square_out,
  output logic signed [SAMPLE_BITS-1:0] pulse_out
);
  import mwo_pkg::*;

  localparam int SIN_AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int EXP_AW  = $clog2(EXP_TABLE_DEPTH);
  localparam int TW      = SAMPLE_BITS + 3;
  localparam int INC_LSB = 56 - PHASE_BITS;
  localparam logic [SAMPLE_BITS-1:0] RAIL_P = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] RAIL_N = {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};
  localparam logic [63:0] SIN_DEN [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};
  localparam logic [63:0] EXP_DEN [14] = '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7,
                                          64'd8, 64'd9, 64'd10, 64'd11, 64'd12, 64'd13,
                                          64'd14};
  localparam logic [33:0] FAC_ONE = 34'd134217728;

  // table generation
  function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int idx);
    logic [63:0] q, quad, r, a, x, x2, term, s;
    logic signed [63:0] sum, m, rail;
    q    = 64'(4 * idx);
    quad = q / SINE_TABLE_DEPTH;
    r    = q % SINE_TABLE_DEPTH;
    a    = quad[0] ? 64'(SINE_TABLE_DEPTH) - r : r;
    x    = HALF_PI_Q30 * a / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / SIN_DEN[k-1];
      if ((k & 1) == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    s    = (sum < 0) ? 64'd0 : unsigned'(sum);
    m    = signed'((s + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS));
    rail = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    if (m > rail) m = rail;
    if (quad >= 64'd2) m = -m;
    return SAMPLE_BITS'(m);
  endfunction

  function automatic logic [16:0] exp_entry(input int idx);
    logic [63:0] x, y, term, sum;
    x    = (64'(idx) << 30) / EXP_TABLE_DEPTH;
    y    = (x * LN2_Q30) >> 30;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * y) >> 30) / EXP_DEN[k-1];
      sum  = sum + term;
    end
    return 17'((sum + 64'd8192) >> 14);
  endfunction

  logic [SAMPLE_BITS-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic [16:0]            exp_rom  [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
    assign sine_rom[g] = sine_entry(g);
  end
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    assign exp_rom[g] = exp_entry(g);
  end

  // working registers
  logic signed [15:0]     fm_q, wm_q, pitch_q, sync_q;
  logic [4:0]             oct_q;
  logic [11:0]            rem_q;
  logic [13:0]            vq;
  logic [EXP_AW-1:0]      idx_q;
  logic [16:0]            exp_q;
  logic [33:0]            ffac, wfac;
  logic [15:0]            width_q;
  logic [32:0]            freq0;
  logic [48:0]            ahi;
  logic [49:0]            lsum;
  logic [21:0]            freq_q;
  logic [39:0]            plo;
  logic [PHASE_BITS-1:0]  inc_q, phase;
  logic                   last_neg;
  logic [SAMPLE_BITS-1:0] sine_q;
  logic [50:0]            prod;

  // combinational helpers
  logic [17:0] w_full;
  logic [16:0] w;
  logic [14:0] q_mul;
  logic [4:0]  q_oct;
  logic [16:0] rem_full;
  logic [24:0] v_full;
  logic [30:0] i_full;
  logic [15:0] fm_mag, wm_mag;
  logic [32:0] mul_a;
  logic [17:0] mul_b;
  logic        ffac_off, wfac_off;
  logic [23:0] wprod;
  logic [15:0] width_next;
  logic [38:0] fsum;
  logic [21:0] freq_next;
  logic [57:0] inc_full;
  logic [31:0] x;
  logic [SAMPLE_BITS:0]   ramp;
  logic signed [TW-1:0]   tri_w;
  logic [SAMPLE_BITS-1:0] tri_out;

  // pitch split into octave and remainder, divide by 3 by reciprocal
  assign w_full   = {{2{pitch_q[15]}}, pitch_q} + 18'd33792;
  assign w        = w_full[16:0];
  assign q_mul    = 15'(w[16:10]) * 15'd171;
  assign q_oct    = q_mul[13:9];
  assign rem_full = w - 17'(q_oct) * 17'd3072;
  assign v_full   = 25'(rem_q) * 25'(EXP_TABLE_DEPTH);
  assign i_full   = 31'(vq) * 31'd43691;

  assign fm_mag = fm_q[15] ? 16'(-fm_q) : 16'(fm_q);
  assign wm_mag = wm_q[15] ? 16'(-wm_q) : 16'(wm_q);

  assign ffac_off = ffac[33] || (ffac == 34'd0);
  assign wfac_off = wfac[33] || (wfac == 34'd0);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SPLIT:   begin mul_a = 33'(fm_mag);        mul_b = 18'(cfg.freq_mod_amount);  end
      OP_IDX1:    begin mul_a = 33'(wm_mag);        mul_b = 18'(cfg.width_mod_amount); end
      OP_EXPRD:   begin mul_a = 33'(wfac[31:0]);    mul_b = 18'(cfg.pulse_width);      end
      OP_BASE:    begin mul_a = 33'(cfg.base_frequency); mul_b = 18'(exp_q);           end
      OP_FMHI:    begin mul_a = freq0;              mul_b = 18'(ffac[31:16]);          end
      OP_FMLO:    begin mul_a = freq0;              mul_b = 18'(ffac[15:0]);           end
      OP_INCLO:   begin mul_a = 33'(freq_q);  mul_b = cfg.phase_step_per_hz[17:0];     end
      OP_INCHI:   begin mul_a = 33'(freq_q);  mul_b = cfg.phase_step_per_hz[35:18];    end
      OP_SINEIDX: begin mul_a = 33'(x);           mul_b = 18'(SINE_TABLE_DEPTH);       end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // pulse width clamp
  assign wprod = prod[50:27];
  always_comb begin
    priority if (wfac_off)                width_next = WIDTH_MIN;
    else if (wprod < 24'(WIDTH_MIN))      width_next = WIDTH_MIN;
    else if (wprod > 24'(WIDTH_MAX))      width_next = WIDTH_MAX;
    else                                  width_next = wprod[15:0];
  end

  // frequency clamp
  assign fsum = 39'(ahi[48:11]) + 39'(lsum[49:27]);
  always_comb begin
    priority if (ffac_off)                freq_next = FREQ_MIN;
    else if (fsum < 39'(FREQ_MIN))        freq_next = FREQ_MIN;
    else if (fsum > 39'(FREQ_MAX))        freq_next = FREQ_MAX;
    else                                  freq_next = fsum[21:0];
  end

  assign inc_full = {prod[39:0], 18'b0} + 58'(plo);

  // phase as a 32-bit turn fraction
  if (PHASE_BITS >= 32) begin : g_x_down
    assign x = phase[PHASE_BITS-1 -: 32];
  end else begin : g_x_up
    assign x = {phase, {(32-PHASE_BITS){1'b0}}};
  end

  assign ramp = x[31 -: SAMPLE_BITS+1];
  always_comb begin
    priority if (x < 32'h4000_0000) tri_w = signed'({2'b00, ramp});
    else if (x < 32'hC000_0000)     tri_w = signed'((TW'(1) << SAMPLE_BITS) - {2'b00, ramp});
    else                            tri_w = signed'({2'b00, ramp} - (TW'(1) << (SAMPLE_BITS+1)));
    tri_out = (tri_w > signed'({3'b000, RAIL_P})) ? RAIL_P : tri_w[SAMPLE_BITS-1:0];
  end

  assign stat.out_free = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      last_neg  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_FINISH && stat.out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == OP_PHASE) begin
        if (last_neg && !sync_q[15]) phase <= '0;
        else phase <= phase + inc_q;
        last_neg <= sync_q[15];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod <= 51'(mul_a) * 51'(mul_b);
    unique case (cmd.op)
      OP_LATCH: begin
        fm_q    <= freq_mod;
        wm_q    <= width_mod;
        pitch_q <= pitch_semitones;
        sync_q  <= sync_in;
      end
      OP_SPLIT: begin
        oct_q <= q_oct;
        rem_q <= rem_full[11:0];
      end
      OP_IDX1: begin
        vq   <= 14'(v_full >> 10);
        ffac <= fm_q[15] ? FAC_ONE - 34'(prod[31:0]) : FAC_ONE + 34'(prod[31:0]);
      end
      OP_IDX2: begin
        idx_q <= EXP_AW'(i_full >> 17);
        wfac  <= wm_q[15] ? FAC_ONE - 34'(prod[31:0]) : FAC_ONE + 34'(prod[31:0]);
      end
      OP_EXPRD:   exp_q   <= exp_rom[idx_q];
      OP_BASE:    width_q <= width_next;
      OP_SHIFT:   freq0   <= 33'(prod[38:0] >> (5'd27 - oct_q));
      OP_FMLO:    ahi     <= prod[48:0];
      OP_FMSUM:   lsum    <= 50'({ahi[10:0], 16'b0}) + 50'(prod[48:0]);
      OP_FCLAMP:  freq_q  <= freq_next;
      OP_INCHI:   plo     <= prod[39:0];
      OP_INCSUM:  inc_q   <= inc_full[INC_LSB +: PHASE_BITS];
      OP_SINERD:  sine_q  <= sine_rom[prod[32 +: SIN_AW]];
      OP_FINISH: begin
        if (stat.out_free) begin
          sine_out     <= sine_q;
          triangle_out <= tri_out;
          saw_out      <= {1'b1, x[31 -: SAMPLE_BITS-1]};
          square_out   <= x[31] ? RAIL_N : RAIL_P;
          pulse_out    <= (x < {width_q, 16'b0}) ? RAIL_P : RAIL_N;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: test/tb_multi_waveform_phase_oscillator_core.sv
module tb_multi_waveform_phase_oscillator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mwo_pkg::*;

  // one result beat, all five waveforms
  typedef struct packed {
    logic signed [15:0] sine;
    logic signed [15:0] tri_w;
    logic signed [15:0] saw;
    logic signed [15:0] square;
    logic signed [15:0] pulse;
  } wave_t;

  // one directed row; want is only used where typed is set
  typedef struct {
    logic signed [15:0] fm;
    logic signed [15:0] wm;
    logic signed [15:0] pitch;
    logic signed [15:0] sync;
    bit                 typed;
    wave_t              want;
  } row_t;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // no register behind this index
  localparam int DRAIN_CYCLES = 40;           // margin past the last beat's trip through the sequencer
  localparam int STALL_LIMIT  = 20000;        // cycles with no beat before giving up
  localparam int RAND_PHASES  = 7;
  localparam int RAND_BEATS   = 250;
  localparam signed [15:0] RAIL = 16'sd32767;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = REG_BASE_FREQ;
  logic [35:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] freq_mod = '0;
  logic signed [15:0] width_mod = '0;
  logic signed [15:0] pitch_semitones = '0;
  logic signed [15:0] sync_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] sine_out, triangle_out, saw_out, square_out, pulse_out;

  multi_waveform_phase_oscillator_core dut (.*);

  initial forever #6 clk = ~clk;

  // predictor state: registers as the block holds them, phase and sync history
  longint base_q8, fm_depth, duty_q16, wm_depth, step_per_hz;
  logic [31:0] osc_phase;
  bit sync_was_neg;
  int sine_rom [1024];
  longint unsigned exp_rom [256];

  wave_t waves_due [$];   // expected waveform beats, oldest first
  int errors, beats_in, beats_out, resyncs;
  int send_idle, recv_idle;
  int phase_no;
  logic hold_on = 1'b0;

  // sin(pi/2 * a/den) in Q30 by a truncated series
  function automatic longint unsigned quarter_sine(longint unsigned a, longint unsigned den);
    longint unsigned x, x2, term;
    longint sum;
    x = HALF_PI_Q30 * a / den;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  function automatic void fill_roms();
    longint unsigned q, quad, r, a, m, x, y, term, sum;
    for (int i = 0; i < 1024; i++) begin
      q = 4 * i;
      quad = q / 1024;
      r = q % 1024;
      a = quad[0] ? 1024 - r : r;
      m = (quarter_sine(a, 1024) + (64'd1 << 14)) >> 15;
      if (m > 32767) m = 32767;
      sine_rom[i] = (quad >= 2) ? -int'(m) : int'(m);
    end
    for (int i = 0; i < 256; i++) begin
      x = (longint'(i) << 30) / 256;
      y = (x * LN2_Q30) >> 30;
      term = Q30_ONE;
      sum = Q30_ONE;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * y) >> 30) / k;
        sum += term;
      end
      exp_rom[i] = (sum + 64'd8192) >> 14;
    end
  endfunction

  // advance the oscillator by one sample and return the waveforms
  function automatic wave_t next_sample(logic signed [15:0] fm, logic signed [15:0] wm,
                                        logic signed [15:0] pitch, logic signed [15:0] sync);
    longint w, octv, rem, factor, ramp, tri_v;
    longint unsigned freq, width;
    logic [95:0] prod;
    wave_t r;
    // whole octaves by floor, remainder picks the exponential entry
    w = longint'(pitch) + 11 * 3072;
    octv = w / 3072 - 11;
    rem = w % 3072;
    freq = (longint'(base_q8) * exp_rom[rem * 256 / 3072]) >> (16 - octv);
    factor = (longint'(1) << 27) + longint'(fm) * fm_depth;
    if (factor <= 0) freq = 0;
    else begin
      prod = 96'(freq) * 96'(factor);
      freq = 64'(prod >> 27);
    end
    if (freq < FREQ_MIN) freq = FREQ_MIN;
    if (freq > FREQ_MAX) freq = FREQ_MAX;
    factor = (longint'(1) << 27) + longint'(wm) * wm_depth;
    width = (factor <= 0) ? 0 : 64'((96'(duty_q16) * 96'(factor)) >> 27);
    if (width < WIDTH_MIN) width = WIDTH_MIN;
    if (width > WIDTH_MAX) width = WIDTH_MAX;
    prod = 96'(freq) * 96'(step_per_hz);
    osc_phase = osc_phase + 32'(prod >> 24);
    // hard sync on a rising zero crossing
    if (sync_was_neg && sync >= 0) begin
      osc_phase = '0;
      resyncs++;
    end
    sync_was_neg = sync < 0;
    r.sine = 16'(sine_rom[osc_phase[31:22]]);
    ramp = longint'(osc_phase >> 15);
    if (osc_phase < 32'h4000_0000) tri_v = ramp;
    else if (osc_phase < 32'hC000_0000) tri_v = 65536 - ramp;
    else tri_v = ramp - 131072;
    if (tri_v > 32767) tri_v = 32767;
    r.tri_w = 16'(tri_v);
    r.saw = 16'(longint'(osc_phase >> 17) - 32768);
    r.square = osc_phase[31] ? -RAIL : RAIL;
    r.pulse = (longint'(osc_phase) < longint'(width << 16)) ? RAIL : -RAIL;
    return r;
  endfunction

  task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
    $display("beat %0d %s: got %0d want %0d", beats_out, what, got, want);
    errors++;
  endtask

  // write all five registers back to back, then, if poke_unused is set, one write to the unused index
  task automatic load_regs(longint bf, longint fa, longint pw, longint wa, longint st,
                           bit poke_unused);
    logic [2:0] idx [6];
    longint val [6];
    int n;
    idx = '{REG_BASE_FREQ, REG_FM_AMOUNT, REG_PULSE_W, REG_WM_AMOUNT, REG_STEP_PERHZ,
            REG_UNUSED};
    val = '{bf, fa, pw, wa, st, longint'({$urandom, $urandom})};
    n = poke_unused ? 6 : 5;
    for (int i = 0; i < n; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= 36'(val[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    // the block keeps only the low register bits
    base_q8 = bf & 64'h3F_FFFF;
    fm_depth = fa & 64'hFFFF;
    duty_q16 = pw & 64'hFFFF;
    wm_depth = wa & 64'hFFFF;
    step_per_hz = st & 64'hF_FFFF_FFFF;
  endtask

  // let every outstanding beat come back before touching the registers
  task automatic drain();
    while (waves_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offer one input beat, return once the block has taken it
  task automatic send_beat(logic signed [15:0] fm, logic signed [15:0] wm,
                           logic signed [15:0] pitch, logic signed [15:0] sync,
                           bit typed, wave_t want);
    wave_t calc;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    freq_mod <= fm;
    width_mod <= wm;
    pitch_semitones <= pitch;
    sync_in <= sync;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = next_sample(fm, wm, pitch, sync);
    waves_due.push_back(typed ? want : calc);
    beats_in++;
  endtask

  // result side: check every beat taken, random stall, long hold-off on request
  int quiet;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      quiet <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (waves_due.size() == 0) begin
          $display("beat %0d: result with nothing expected", beats_out);
          errors++;
        end else begin
          wave_t w;
          w = waves_due.pop_front();
          if (sine_out !== w.sine) report("sine", sine_out, w.sine);
          if (triangle_out !== w.tri_w) report("triangle", triangle_out, w.tri_w);
          if (saw_out !== w.saw) report("saw", saw_out, w.saw);
          if (square_out !== w.square) report("square", square_out, w.square);
          if (pulse_out !== w.pulse) report("pulse", pulse_out, w.pulse);
        end
        beats_out++;
      end
      out_stall <= hold_on || ($urandom_range(99) < recv_idle);
      // watchdog on cycles where neither channel moves
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet <= 0;
      else if (quiet >= STALL_LIMIT) begin
        $display("timeout with %0d beats outstanding", waves_due.size());
        $display("multi_waveform_phase_oscillator_core: mismatch");
        $finish;
      end else quiet <= quiet + 1;
    end
  end

  // long receiver hold-off while the sender keeps offering, so the input backs up
  initial begin
    wait (phase_no == 3);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (300) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    row_t rows [$];
    wave_t at_zero;
    wave_t none;
    logic signed [15:0] fm, wm, pitch, sync;
    bit neg;
    fill_roms();
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    resyncs = 0;
    phase_no = 0;
    base_q8 = 0;
    fm_depth = 0;
    duty_q16 = 0;
    wm_depth = 0;
    step_per_hz = longint'(STEP_RESET);
    osc_phase = '0;
    sync_was_neg = 1'b0;
    send_idle = 12;
    recv_idle = 71;
    none = '0;
    // phase forced to zero: saw at the bottom rail, square and pulse high
    at_zero = '{sine: 16'sd0, tri_w: 16'sd0, saw: -16'sd32768, square: RAIL, pulse: RAIL};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, first at reset register values
    rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd0, 16'sd0, -16'sd1, 1'b0, none},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, at_zero},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, none},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, none},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1, at_zero},
      '{16'sd0, 16'sd0, 16'sd3072, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd0, -16'sd3072, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd0, -16'sd1, 16'sd0, 1'b0, none},
      '{16'sd16384, -16'sd16384, 16'sd1536, -16'sd32768, 1'b0, none},
      '{-16'sd16384, 16'sd16384, 16'sd255, -16'sd1, 1'b0, none},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, at_zero},
      '{16'sd32767, 16'sd0, 16'sd8000, 16'sd1, 1'b0, none},
      '{-16'sd32768, 16'sd0, -16'sd8000, 16'sd1, 1'b0, none},
      '{16'sd0, 16'sd32767, 16'sd100, 16'sd1, 1'b0, none},
      '{16'sd0, -16'sd32768, -16'sd100, 16'sd1, 1'b0, none}
    };
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain();
        // a 440 Hz tone with moderate depths on both modulations
        load_regs(112640, 4096, 32768, 4096, longint'(STEP_RESET), 1'b0);
      end
      foreach (rows[i])
        send_beat(rows[i].fm, rows[i].wm, rows[i].pitch, rows[i].sync,
                  rows[i].typed, rows[i].want);
      in_valid <= 1'b0;
    end

    // random phases, each with its own register setting
    neg = 1'b0;
    for (int p = 1; p <= RAND_PHASES; p++) begin
      drain();
      if (p <= 2) begin
        send_idle = 12;
        recv_idle = 71;
      end else if (p <= 5) begin
        send_idle = 71;
        recv_idle = 12;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 1) load_regs(4194303, 65535, 65535, 65535, 64'hF_FFFF_FFFF, 1'b1);
      else if (p == 2) load_regs(0, 0, 0, 0, 0, 1'b0);
      else
        load_regs($urandom_range(0, 4194303), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 1) ? longint'(STEP_RESET) + $urandom_range(0, 65535)
                                       : longint'({$urandom, $urandom}), 1'b0);
      phase_no = p;
      for (int n = 0; n < RAND_BEATS; n++) begin
        fm = $urandom_range(0, 1) ? 16'($urandom) : 16'($signed($urandom_range(0, 4095)) - 2048);
        wm = 16'($urandom);
        pitch = ($urandom_range(0, 9) < 7) ? 16'($signed($urandom_range(0, 18432)) - 9216)
                                           : 16'($urandom);
        // sync mostly holds its sign so the phase runs for a while between resets
        if ($urandom_range(0, 99) < 12) neg = ~neg;
        sync = 16'($urandom);
        if ($urandom_range(0, 9) != 0) sync[15] = neg;
        send_beat(fm, wm, pitch, sync, 1'b0, none);
      end
      in_valid <= 1'b0;
    end

    drain();
    $display("%0d input beats, %0d results checked, %0d hard syncs, %0d register settings",
             beats_in, beats_out, resyncs, RAND_PHASES + 2);
    $display("covered reset values, register extremes, the unused index and a long stall");
    if (errors == 0 && waves_due.size() == 0) begin
      $display("multi_waveform_phase_oscillator_core: match");
    end else begin
      $display("multi_waveform_phase_oscillator_core: mismatch");
    end
    $finish;
  end

endmodule
